[sv/lzwe_pkg.sv]
`timescale 1ns / 1ps
package lzwe_pkg;

  localparam int CHAR_W = 7;
  localparam int CODE_W = 12;
  localparam int KEY_W = CODE_W + CHAR_W;
  localparam int ENTRY_W = 1 + KEY_W + CODE_W;
  localparam int PEND_W = 5;

  localparam int DEFAULT_HASH_SLOTS = 8192;
  localparam int ALPHABET_SIZE = 128;
  localparam int HASH_MULT = 40503;

  localparam logic [CODE_W-1:0] FIRST_FREE_CODE = CODE_W'(ALPHABET_SIZE);
  localparam logic [CODE_W-1:0] LAST_CODE = 12'd4095;
  localparam logic [CODE_W-1:0] RESET_CODE = 12'hFFF;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_RD,
    S_CMP,
    S_INSERT,
    S_LOAD,
    S_BYTE,
    S_PAD
  } state_t;

endpackage

[sv/lzwe_if.sv]
`timescale 1ns / 1ps
interface lzwe_in_if;
  logic                         valid;
  logic                         ready;
  logic [lzwe_pkg::CHAR_W-1:0]  in_char;
  logic                         end_of_data;

  modport source (output valid, output in_char, output end_of_data, input ready);
  modport sink (input valid, input in_char, input end_of_data, output ready);
endinterface

interface lzwe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_stream;

  modport source (output valid, output out_byte, output last_of_run,
                  output end_of_stream, input ready);
  modport sink (input valid, input out_byte, input last_of_run,
                input end_of_stream, output ready);
endinterface

[sv/lzw_encoder_12bit.sv]
`timescale 1ns / 1ps
// LZW compressor, 7-bit characters in, packed 12-bit codes out MSB first.
// text: one character a beat (in_char, end_of_data marks the final one).
// code_bytes: one packed byte a beat; last_of_run flags the last byte an
// input beat caused, end_of_stream the final byte (zero-padded if partial).
// Dictionary pairs live in a HASH_SLOTS-entry single memory, linear probe.
// Per character: accept, home slot (product register if HASH_SLOTS is a
// power of two, else product, quotient and remainder registers), a read
// and a compare state per probe. A hit ends there unless it ends the text.
// A miss adds an insert state, a load state per code and a byte state per
// byte emitted, up to 5 bytes. text.ready is high only between characters.
// After reset, each dictionary wrap (code 4095) and each end_of_data the
// memory is cleared one entry a cycle, text.ready low. When code_bytes
// stalls, the byte register holds and the encoder waits; an accepted
// character may sit in progress while the previous one's last byte waits.
module lzw_encoder_12bit #(
  parameter int HASH_SLOTS = lzwe_pkg::DEFAULT_HASH_SLOTS
) (
  input logic       clk,
  input logic       rst,
  lzwe_in_if.sink   text,
  lzwe_out_if.source code_bytes
);

  localparam int SLOT_W = $clog2(HASH_SLOTS);
  localparam int CODE_W = lzwe_pkg::CODE_W;
  localparam int KEY_W = lzwe_pkg::KEY_W;
  localparam int ENTRY_W = lzwe_pkg::ENTRY_W;
  localparam int PEND_W = lzwe_pkg::PEND_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HASH_SLOTS - 1);

  lzwe_pkg::state_t state, state_next;

  logic [ENTRY_W-1:0]  mem [HASH_SLOTS];
  logic [ENTRY_W-1:0]  rdata;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;

  logic [lzwe_pkg::CHAR_W-1:0] ch;
  logic                eod;
  logic [CODE_W-1:0]   prefix;
  logic                have_prefix;
  logic [CODE_W-1:0]   next_code;
  logic [15:0]         bitbuf;
  logic [PEND_W-1:0]   pend;
  logic [CODE_W-1:0]   q0, q1, q2;
  logic [1:0]          qn;
  logic [SLOT_W-1:0]   probe;
  logic [SLOT_W-1:0]   home;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   sweep;
  logic                clr_mid;
  logic                ovalid;
  logic [7:0]          obyte;
  logic                olast;
  logic                oeos;

  logic                hash_start;
  logic                hash_done;
  logic [SLOT_W-1:0]   hash_home;
  logic                out_free;
  logic                out_load;
  logic                e_valid;
  logic [KEY_W-1:0]    e_key;
  logic [CODE_W-1:0]   e_code;
  logic                hit;
  logic                full;
  logic [PEND_W-1:0]   pend_after;
  logic [7:0]          byte_now;
  logic                byte_last;

  lzwe_hash #(.HASH_SLOTS(HASH_SLOTS)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   ({prefix, text.in_char}),
    .done  (hash_done),
    .home  (hash_home)
  );

  // Dictionary memory: one write port, registered read at the probe slot
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[probe];
  end

  assign e_valid    = rdata[ENTRY_W-1];
  assign e_key      = rdata[ENTRY_W-2:CODE_W];
  assign e_code     = rdata[CODE_W-1:0];
  assign hit        = e_valid && (e_key == {prefix, ch});
  assign full       = next_code >= lzwe_pkg::LAST_CODE;
  assign out_free   = !ovalid || code_bytes.ready;
  assign out_load   = out_free &&
                      ((state == lzwe_pkg::S_BYTE && pend >= PEND_W'(8)) ||
                       state == lzwe_pkg::S_PAD);
  assign pend_after = pend - PEND_W'(8);
  assign byte_now   = 8'(bitbuf >> pend_after);
  assign byte_last  = (pend_after < PEND_W'(8)) && (qn == 2'd0) &&
                      !(eod && pend_after != '0);

  assign text.ready               = (state == lzwe_pkg::S_IDLE);
  assign code_bytes.valid         = ovalid;
  assign code_bytes.out_byte      = obyte;
  assign code_bytes.last_of_run   = olast;
  assign code_bytes.end_of_stream = oeos;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzwe_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory write port
  always_comb begin
    state_next = state;
    hash_start = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = slot;
    mem_wdata  = {1'b1, prefix, ch, next_code};
    unique case (state)
      lzwe_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep;
        mem_wdata = '0;
        if (sweep == LAST_SLOT) begin
          state_next = clr_mid ? lzwe_pkg::S_INSERT : lzwe_pkg::S_IDLE;
        end
      end
      lzwe_pkg::S_IDLE: begin
        if (text.valid) begin
          if (have_prefix) begin
            hash_start = 1'b1;
            state_next = lzwe_pkg::S_HASH;
          end else if (text.end_of_data) begin
            state_next = lzwe_pkg::S_LOAD;
          end
        end
      end
      lzwe_pkg::S_HASH: begin
        if (hash_done) begin
          state_next = lzwe_pkg::S_RD;
        end
      end
      lzwe_pkg::S_RD: begin
        state_next = lzwe_pkg::S_CMP;
      end
      lzwe_pkg::S_CMP: begin
        if (!e_valid) begin
          state_next = full ? lzwe_pkg::S_CLEAR : lzwe_pkg::S_INSERT;
        end else if (hit) begin
          state_next = eod ? lzwe_pkg::S_LOAD : lzwe_pkg::S_IDLE;
        end else begin
          state_next = lzwe_pkg::S_RD;
        end
      end
      lzwe_pkg::S_INSERT: begin
        mem_we     = 1'b1;
        state_next = lzwe_pkg::S_LOAD;
      end
      lzwe_pkg::S_LOAD: begin
        state_next = lzwe_pkg::S_BYTE;
      end
      lzwe_pkg::S_BYTE: begin
        if (pend < PEND_W'(8)) begin
          if (qn != 2'd0) begin
            state_next = lzwe_pkg::S_LOAD;
          end else if (eod && pend != '0) begin
            state_next = lzwe_pkg::S_PAD;
          end else begin
            state_next = eod ? lzwe_pkg::S_CLEAR : lzwe_pkg::S_IDLE;
          end
        end
      end
      lzwe_pkg::S_PAD: begin
        if (out_free) begin
          state_next = lzwe_pkg::S_CLEAR;
        end
      end
      default: state_next = lzwe_pkg::S_IDLE;
    endcase
  end

  // Datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prefix <= 1'b0;
      prefix      <= '0;
      next_code   <= lzwe_pkg::FIRST_FREE_CODE;
      bitbuf      <= '0;
      pend        <= '0;
      qn          <= '0;
      sweep       <= '0;
      clr_mid     <= 1'b0;
      ovalid      <= 1'b0;
    end else begin
      // Raise valid on a new byte, drop it once taken
      if (out_load) begin
        ovalid <= 1'b1;
      end else if (code_bytes.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        lzwe_pkg::S_CLEAR: begin
          sweep <= (sweep == LAST_SLOT) ? '0 : sweep + 1'b1;
          if (clr_mid) begin
            slot <= home;
            if (sweep == LAST_SLOT) begin
              clr_mid <= 1'b0;
            end
          end else begin
            have_prefix <= 1'b0;
            prefix      <= '0;
            next_code   <= lzwe_pkg::FIRST_FREE_CODE;
            bitbuf      <= '0;
            pend        <= '0;
          end
        end
        lzwe_pkg::S_IDLE: begin
          if (text.valid) begin
            ch  <= text.in_char;
            eod <= text.end_of_data;
            if (!have_prefix) begin
              prefix      <= CODE_W'(text.in_char);
              have_prefix <= 1'b1;
              q0          <= CODE_W'(text.in_char);
              qn          <= text.end_of_data ? 2'd1 : 2'd0;
            end
          end
        end
        lzwe_pkg::S_HASH: begin
          if (hash_done) begin
            probe <= hash_home;
            home  <= hash_home;
          end
        end
        lzwe_pkg::S_RD: begin
        end
        lzwe_pkg::S_CMP: begin
          if (!e_valid) begin
            slot <= probe;
            q0   <= prefix;
            if (full) begin
              q1        <= lzwe_pkg::RESET_CODE;
              q2        <= CODE_W'(ch);
              qn        <= eod ? 2'd3 : 2'd2;
              next_code <= lzwe_pkg::FIRST_FREE_CODE;
              clr_mid   <= 1'b1;
            end else begin
              q1 <= CODE_W'(ch);
              qn <= eod ? 2'd2 : 2'd1;
            end
          end else if (hit) begin
            prefix <= e_code;
            q0     <= e_code;
            qn     <= eod ? 2'd1 : 2'd0;
          end else begin
            probe <= (probe == LAST_SLOT) ? '0 : probe + 1'b1;
          end
        end
        lzwe_pkg::S_INSERT: begin
          next_code <= next_code + 1'b1;
          prefix    <= CODE_W'(ch);
        end
        lzwe_pkg::S_LOAD: begin
          // Shift the next code into the bit buffer
          bitbuf <= {bitbuf[15-CODE_W:0], q0};
          pend   <= pend + PEND_W'(CODE_W);
          q0     <= q1;
          q1     <= q2;
          qn     <= qn - 1'b1;
        end
        lzwe_pkg::S_BYTE: begin
          if (pend >= PEND_W'(8) && out_free) begin
            obyte  <= byte_now;
            olast  <= byte_last;
            oeos   <= byte_last && eod;
            pend   <= pend_after;
          end
        end
        lzwe_pkg::S_PAD: begin
          if (out_free) begin
            obyte  <= {bitbuf[3:0], 4'b0000};
            olast  <= 1'b1;
            oeos   <= 1'b1;
            pend   <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // No character is taken while the memory is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == lzwe_pkg::S_CLEAR) |-> !text.ready)
    else $error("character accepted during dictionary clear");

  // Between characters at most four bits wait in the buffer
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == lzwe_pkg::S_IDLE) |-> (pend == PEND_W'(0) || pend == PEND_W'(4)))
    else $error("bit buffer misaligned between characters");

  // Insert follows a probe miss or a wrap clear
  a_insert_src: assert property (@(posedge clk) disable iff (rst)
    (state == lzwe_pkg::S_INSERT) |->
      ($past(state) == lzwe_pkg::S_CMP || $past(state) == lzwe_pkg::S_CLEAR))
    else $error("insert without a preceding miss");

  // Hash completion only while waiting for it
  a_hash_done: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == lzwe_pkg::S_HASH))
    else $error("hash result outside lookup");

endmodule

[sv/lzwe_hash.sv]
`timescale 1ns / 1ps
module lzwe_hash #(
  parameter int HASH_SLOTS = lzwe_pkg::DEFAULT_HASH_SLOTS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lzwe_pkg::KEY_W-1:0]  key,
  output logic                        done,
  output logic [$clog2(HASH_SLOTS)-1:0] home
);

  localparam int SLOT_W = $clog2(HASH_SLOTS);
  localparam int PROD_W = lzwe_pkg::KEY_W + 16;

  generate
    if ((1 << SLOT_W) == HASH_SLOTS) begin : g_pow2
      logic [PROD_W-1:0] prod;

      // Home slot is the low bits of the product
      assign prod = PROD_W'(key) * PROD_W'(lzwe_pkg::HASH_MULT);

      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          home <= prod[SLOT_W-1:0];
        end
      end
    end else begin : g_recip
      localparam int RECIP_W = 21;
      localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / HASH_SLOTS);
      logic [31:0]          prod;
      logic [31:0]          prod_lo;
      logic [RECIP_W-1:0]   quot;
      logic [52:0]          qprod;
      logic [37:0]          back;
      logic [31:0]          rem0;
      logic [31:0]          rem1;
      logic                 s1;
      logic                 s2;

      // Product wraps at 32 bits before the slot reduction
      assign prod = 32'(PROD_W'(key) * PROD_W'(lzwe_pkg::HASH_MULT));

      // Estimate the quotient by reciprocal, it is low by at most one
      assign qprod = 53'(prod_lo) * 53'(RECIP);
      assign back  = 38'(quot) * 38'(HASH_SLOTS);
      assign rem0  = prod_lo - back[31:0];
      assign rem1  = (rem0 >= 32'(HASH_SLOTS)) ? rem0 - 32'(HASH_SLOTS) : rem0;

      always_ff @(posedge clk) begin
        if (rst) begin
          s1   <= 1'b0;
          s2   <= 1'b0;
          done <= 1'b0;
        end else begin
          s1   <= start;
          s2   <= s1;
          done <= s2;
        end
        if (start) begin
          prod_lo <= prod;
        end
        if (s1) begin
          quot <= qprod[52:32];
        end
        if (s2) begin
          home <= rem1[SLOT_W-1:0];
        end
      end
    end
  endgenerate

endmodule
